/* rtl/core/ahsr_pkg.sv */
// Shared types, constants and scaling function for the averaged hysteresis step regulator.
package ahsr_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned RUN_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DRIVE = 1'b1;

  localparam logic [LEVEL_W-1:0] HYST_RST  = 8'd10;
  localparam logic [LEVEL_W-1:0] DRIVE_RST = 8'd127;
  localparam logic [LEVEL_W-1:0] DRIVE_MAX = 8'd255;
  localparam logic [LEVEL_W-1:0] DRIVE_MIN = 8'd0;
  localparam logic [RUN_W-1:0]   RUN_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [SAMPLE_W-1:0] feedback_sample;
    logic [SAMPLE_W-1:0] setpoint_sample;
  } ahsr_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] drive;
    logic [LEVEL_W-1:0] window_mean;
    logic [RUN_W-1:0]   longest_run;
  } ahsr_out_t;

  // floor(x*255/1023): y = 255x, then floor(y/1023) = (y + (y>>10) + 1) >> 10
  // holds for every y below 1023*1024.
  function automatic logic [LEVEL_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] x);
    logic [17:0] y;
    logic [17:0] t;
    y = {x, 8'b0} - {8'b0, x};
    t = y + {10'b0, y[17:10]} + 18'd1;
    return t[17:10];
  endfunction

endpackage

/* rtl/core/averaged_hysteresis_step_regulator.sv */
// Top level of the averaged hysteresis step regulator.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------------
//  in       | in_valid_i / in_ready_o      | in_data_i  (feedback_sample, setpoint_sample)
//  out      | out_valid_o / out_ready_i    | out_data_o (drive, window_mean, longest_run)
//  config   | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while out_ready_i holds high; each item goes from accept
// to result valid through window push and setpoint scaling into the input stage, then
// mean, step decision and run tracking into the output register.
// The input stage holds while the output register is full and not read; it empties
// and takes a new item in the same cycle, so input stalls only when both are occupied.
// Reset clears the window, run counters and report counters; drive starts at 127.
// Writing initial_drive loads the drive level at once.
module averaged_hysteresis_step_regulator import ahsr_pkg::*; #(
  parameter int unsigned WINDOW_LEN    = 15,
  parameter int unsigned REPORT_PERIOD = 500,
  parameter int unsigned CLEAR_PERIODS = 100
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ahsr_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ahsr_out_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // window sum width and reciprocal for the truncating divide by WINDOW_LEN
  localparam int unsigned LOG_N       = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W       = LEVEL_W + LOG_N;
  localparam int unsigned RECIP_SHIFT = SUM_W + LOG_N;
  localparam int unsigned RECIP_MULT  = ((1 << RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int unsigned PROD_W      = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] RECIP    = (SUM_W+1)'(RECIP_MULT);

  localparam int unsigned TICK_W = $clog2(REPORT_PERIOD + 1);
  localparam int unsigned PER_W  = $clog2(CLEAR_PERIODS + 1);
  localparam logic [TICK_W-1:0] TICK_END = TICK_W'(REPORT_PERIOD);
  localparam logic [TICK_W-1:0] TICK_ONE = TICK_W'(1);
  localparam logic [PER_W-1:0]  PER_END  = PER_W'(CLEAR_PERIODS);
  localparam logic [PER_W-1:0]  PER_ONE  = PER_W'(1);

  // pipeline control
  logic v1_q, out_valid_q;
  logic r1, r2;
  logic load1, load2;

  assign r2    = !out_valid_q || out_ready_i;
  assign r1    = !v1_q || r2;
  assign load1 = in_valid_i && r1;
  assign load2 = v1_q && r2;

  assign in_ready_o  = r1;
  assign out_valid_o = out_valid_q;

  // input stage: scale and push into the window (window sum is the stage register)
  logic [LEVEL_W-1:0] fb_scaled;
  logic [LEVEL_W-1:0] s1_sp_q;
  logic [SUM_W-1:0]   win_sum;

  assign fb_scaled = scale_sample(in_data_i.feedback_sample);

  ahsr_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (load1),
    .sample_i (fb_scaled),
    .sum_o    (win_sum)
  );

  always_ff @(posedge clk_i) begin
    if (load1) begin
      s1_sp_q <= scale_sample(in_data_i.setpoint_sample);
    end
  end

  // mean = sum / WINDOW_LEN by reciprocal multiply
  logic [PROD_W-1:0]  mean_prod;
  logic [LEVEL_W-1:0] win_mean;

  assign mean_prod = PROD_W'(win_sum) * PROD_W'(RECIP);
  assign win_mean  = mean_prod[RECIP_SHIFT +: LEVEL_W];

  // report counters, step decision and run tracking
  logic [LEVEL_W-1:0] hyst_q;
  logic [LEVEL_W-1:0] drive_q, drive_d;
  logic [RUN_W-1:0]   up_run_q, up_run_d;
  logic [RUN_W-1:0]   down_run_q, down_run_d;
  logic [RUN_W-1:0]   run_max_q, run_max_d;
  logic [TICK_W-1:0]  tick_q, tick_d;
  logic [PER_W-1:0]   period_q, period_d;
  logic [RUN_W-1:0]   run_max_base;
  logic [PER_W-1:0]   period_inc;
  logic [LEVEL_W:0]   mean_plus_h;
  logic [LEVEL_W:0]   sp_plus_h;
  logic               step_down, step_up;
  ahsr_out_t          out_q, out_d;

  always_comb begin
    period_inc   = period_q + PER_ONE;
    period_d     = period_q;
    run_max_base = run_max_q;
    tick_d       = tick_q + TICK_ONE;
    if (tick_q == TICK_END) begin
      tick_d = TICK_ONE;
      if (period_inc == PER_END) begin
        period_d     = '0;
        run_max_base = '0;
      end else begin
        period_d = period_inc;
      end
    end

    // mean < sp - h  <=>  mean + h < sp ;  mean > sp + h, all unsigned
    mean_plus_h = {1'b0, win_mean} + {1'b0, hyst_q};
    sp_plus_h   = {1'b0, s1_sp_q} + {1'b0, hyst_q};
    step_down   = (mean_plus_h < {1'b0, s1_sp_q}) && (drive_q != DRIVE_MIN);
    step_up     = !step_down && ({1'b0, win_mean} > sp_plus_h) && (drive_q != DRIVE_MAX);

    drive_d    = drive_q;
    up_run_d   = up_run_q;
    down_run_d = down_run_q;
    run_max_d  = run_max_base;
    if (step_down) begin
      if (up_run_q > run_max_base) begin
        run_max_d = up_run_q;
      end
      drive_d    = drive_q - 8'd1;
      down_run_d = (down_run_q == RUN_MAX) ? down_run_q : down_run_q + 16'd1;
      up_run_d   = '0;
    end else if (step_up) begin
      if (down_run_q > run_max_base) begin
        run_max_d = down_run_q;
      end
      drive_d    = drive_q + 8'd1;
      up_run_d   = (up_run_q == RUN_MAX) ? up_run_q : up_run_q + 16'd1;
      down_run_d = '0;
    end

    out_d.drive       = drive_d;
    out_d.window_mean = win_mean;
    out_d.longest_run = run_max_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
      hyst_q      <= HYST_RST;
      drive_q     <= DRIVE_RST;
      up_run_q    <= '0;
      down_run_q  <= '0;
      run_max_q   <= '0;
      tick_q      <= '0;
      period_q    <= '0;
    end else begin
      if (load1) begin
        v1_q <= 1'b1;
      end else if (load2) begin
        v1_q <= 1'b0;
      end
      if (load2) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (load2) begin
        drive_q    <= drive_d;
        up_run_q   <= up_run_d;
        down_run_q <= down_run_d;
        run_max_q  <= run_max_d;
        tick_q     <= tick_d;
        period_q   <= period_d;
      end

      // config writes must arrive only while idle; the block itself does not enforce it
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HYSTERESIS:    hyst_q  <= cfg_data_i;
          CFG_INITIAL_DRIVE: drive_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load2) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  a_drive_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load2 |=> (drive_q == $past(drive_q)) || (drive_q == $past(drive_q) + 8'd1) ||
              (drive_q == $past(drive_q) - 8'd1))
    else $error("drive moved by more than one step");

  a_runs_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((up_run_q != '0) && (down_run_q != '0)))
    else $error("up and down runs both active");

  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q <= TICK_END)
    else $error("tick counter past report period");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> in_ready_o)
    else $error("input stalled with empty first stage");

endmodule

/* rtl/core/ahsr_window.sv */
// Sliding window of scaled feedback samples with a running sum.
module ahsr_window import ahsr_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 15,
  parameter int unsigned SUM_W      = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [LEVEL_W-1:0] sample_i,
  output logic [SUM_W-1:0]   sum_o
);

  logic [LEVEL_W-1:0] win_q [WINDOW_LEN];
  logic [SUM_W-1:0]   sum_q;
  logic [SUM_W-1:0]   sum_d;

  // modular arithmetic; the final value is always in range
  assign sum_d = sum_q + SUM_W'(sample_i) - SUM_W'(win_q[WINDOW_LEN-1]);
  assign sum_o = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        win_q[k] <= '0;
      end
      sum_q <= '0;
    end else if (push_i) begin
      win_q[0] <= sample_i;
      for (int k = 1; k < WINDOW_LEN; k++) begin
        win_q[k] <= win_q[k-1];
      end
      sum_q <= sum_d;
    end
  end

  localparam logic [SUM_W:0] SUM_LIMIT = (SUM_W+1)'(255 * WINDOW_LEN);

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, sum_q} <= SUM_LIMIT)
    else $error("window sum out of range");

endmodule
